>>> hw/rtl/gb3_pkg.sv
`default_nettype none

package gb3_pkg;

    localparam int PIX_W            = 8;
    localparam int FW_W             = 11;
    localparam int FH_W             = 13;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 13;
    localparam int SUM_W            = 12;
    localparam int BLUR_SHIFT       = 4;
    localparam int MIN_DIM          = 3;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel_in;
    } in_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } out_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } line_pair_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

endpackage

`default_nettype wire

>>> hw/rtl/gb3_line_buf.sv
`default_nettype none

module gb3_line_buf #(
    parameter int MAX_WIDTH = gb3_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire                  aclk,
    input  wire                  rd_en,
    input  wire [ADDR_W-1:0]     rd_addr,
    output gb3_pkg::line_pair_t  rd_data,
    input  wire                  wr_en,
    input  wire [ADDR_W-1:0]     wr_addr,
    input  gb3_pkg::line_pair_t  wr_data
);

    logic [gb3_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [gb3_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
    gb3_pkg::line_pair_t       rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= wr_data.upper;
            middle_mem[wr_addr] <= wr_data.middle;
        end
        if (rd_en) begin
            rd_data_reg.upper  <= upper_mem[rd_addr];
            rd_data_reg.middle <= middle_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gb3_window.sv
`default_nettype none

module gb3_window (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        shift_en,
    input  gb3_pkg::col_t              col,
    output logic [gb3_pkg::PIX_W-1:0]  blur_pix,
    output logic [gb3_pkg::PIX_W-1:0]  center_pix
);

    localparam int SW = gb3_pkg::SUM_W;

    logic [gb3_pkg::PIX_W-1:0] win_reg  [3][3];
    logic [gb3_pkg::PIX_W-1:0] win_next [3][3];
    logic [SW-1:0]             sum;

    // window after the new column shifts in
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = col.top;
        win_next[1][2] = col.mid;
        win_next[2][2] = col.bot;
    end

    always_comb begin
        sum = SW'(win_next[0][0])        + (SW'(win_next[0][1]) << 1) + SW'(win_next[0][2])
            + (SW'(win_next[1][0]) << 1) + (SW'(win_next[1][1]) << 2)
            + (SW'(win_next[1][2]) << 1)
            + SW'(win_next[2][0])        + (SW'(win_next[2][1]) << 1) + SW'(win_next[2][2]);
    end

    assign blur_pix   = sum[gb3_pkg::BLUR_SHIFT +: gb3_pkg::PIX_W];
    assign center_pix = win_next[1][1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (shift_en) begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gaussian_blur_3x3_raster_top.sv
`default_nettype none

// channel  | valid     | ready     | data                      | beat
// ---------+-----------+-----------+---------------------------+-------------------------
// input    | s_valid   | s_ready   | s_data (func, pixel_in)   | one pixel or drain tick
// output   | m_valid   | m_ready   | m_data (pixel_out, last)  | one output pixel
// config   | cfg_valid | cfg_ready | cfg_index, cfg_data       | one register write
//
// one beat per clock sustained while not busy and the output is not stalled; a pixel passes
// the line buffer read into the stage register, then window and blur into the output register
// after reset the line buffers are cleared, one address a cycle, while s_ready is low
// a config write re-derives the line buffer columns with a bit-serial remainder:
// s_ready stays low until the remainder is done
// a stalled output holds one result and one item in flight before s_ready drops

module gaussian_blur_3x3_raster_top #(
    parameter int MAX_WIDTH = gb3_pkg::DEF_MAX_WIDTH
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  gb3_pkg::in_beat_t                   s_data,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output gb3_pkg::out_beat_t                  m_data,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [gb3_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [gb3_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int PW     = gb3_pkg::PIX_W;
    localparam int FH_W   = gb3_pkg::FH_W;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W  = $clog2(MAX_WIDTH * gb3_pkg::HEIGHT_LIMIT);
    localparam int SIZE_W = $clog2(MAX_WIDTH * gb3_pkg::HEIGHT_LIMIT + 1);
    localparam int EXT_W  = SIZE_W + 1;
    localparam int DIV_W  = CNT_W + 1;
    localparam int DCNT_W = $clog2(DIV_W + 2);

    typedef struct packed {
        logic              emit;
        logic              blur_sel;
        logic              last;
        logic [PW-1:0]     pix;
        logic [ADDR_W-1:0] addr;
    } stage_t;

    // configuration and derived sizes
    logic [gb3_pkg::FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0]          frame_height_reg;
    logic [WID_W-1:0]         w_eff_reg;
    logic [FH_W-1:0]          h_eff_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [EXT_W-1:0]         fw_x;
    logic [EXT_W-1:0]         w_eff_next;
    logic [FH_W-1:0]          h_eff_next;
    logic [WID_W+FH_W-1:0]    size_prod;

    // counters
    logic [CNT_W-1:0]  input_count_reg;
    logic [CNT_W-1:0]  output_count_reg;
    logic [ADDR_W-1:0] in_col_reg;
    logic [ADDR_W-1:0] oc_col_reg;

    // clearing pass
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // column remainder unit
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DIV_W-1:0]  div_in_reg;
    logic [DIV_W-1:0]  div_oc_reg;
    logic [WID_W-1:0]  rem_in_reg;
    logic [WID_W-1:0]  rem_oc_reg;
    logic [WID_W-1:0]  rem_in_next;
    logic [WID_W-1:0]  rem_oc_next;

    // pipeline
    logic                s1_valid_reg;
    stage_t              s1_reg;
    stage_t              s1_next;
    logic                fwd_valid_reg;
    gb3_pkg::line_pair_t fwd_reg;
    logic                out_valid_reg;
    gb3_pkg::out_beat_t  out_data_reg;

    // control
    logic                busy;
    logic                out_free;
    logic                s1_adv;
    logic                in_acc;
    logic                cfg_acc;
    logic [EXT_W-1:0]    w_x;
    logic [EXT_W-1:0]    size_x;
    logic [EXT_W-1:0]    c_x;
    logic [EXT_W-1:0]    p_x;
    logic                tail;
    logic                is_drain;
    logic                push;
    logic                in_wrap;
    logic [ADDR_W-1:0]   in_col_inc;
    logic [ADDR_W-1:0]   oc_col_inc;

    // memory and window
    gb3_pkg::line_pair_t rd_data;
    gb3_pkg::line_pair_t eff_pair;
    gb3_pkg::line_pair_t upd_pair;
    gb3_pkg::line_pair_t wr_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    gb3_pkg::col_t       win_col;
    logic [PW-1:0]       blur_pix;
    logic [PW-1:0]       center_pix;

    function automatic logic [WID_W-1:0] rem_step(
        input logic [WID_W-1:0] rem,
        input logic             bit_in,
        input logic [WID_W-1:0] w
    );
        logic [WID_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, w}) begin
            t = t - {1'b0, w};
        end
        return t[WID_W-1:0];
    endfunction

    // derived sizes, clamped
    always_comb begin
        fw_x = EXT_W'(frame_width_reg);
        if (fw_x < EXT_W'(gb3_pkg::MIN_DIM)) begin
            w_eff_next = EXT_W'(gb3_pkg::MIN_DIM);
        end else if (fw_x > EXT_W'(MAX_WIDTH)) begin
            w_eff_next = EXT_W'(MAX_WIDTH);
        end else begin
            w_eff_next = fw_x;
        end
        if (frame_height_reg < FH_W'(gb3_pkg::MIN_DIM)) begin
            h_eff_next = FH_W'(gb3_pkg::MIN_DIM);
        end else if (frame_height_reg > FH_W'(gb3_pkg::HEIGHT_LIMIT)) begin
            h_eff_next = FH_W'(gb3_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff_next = frame_height_reg;
        end
        size_prod = (WID_W + FH_W)'(w_eff_reg) * (WID_W + FH_W)'(h_eff_reg);
    end

    always_ff @(posedge aclk) begin
        w_eff_reg <= w_eff_next[WID_W-1:0];
        h_eff_reg <= h_eff_next;
        size_reg  <= size_prod[SIZE_W-1:0];
    end

    // handshake
    assign busy      = clr_busy_reg || (div_cnt_reg != '0);
    assign out_free  = !out_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && (!s1_reg.emit || out_free);
    assign s_ready   = !busy && (!s1_valid_reg || s1_adv);
    assign in_acc    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // item decode
    always_comb begin
        w_x      = EXT_W'(w_eff_reg);
        size_x   = EXT_W'(size_reg);
        c_x      = EXT_W'(output_count_reg);
        p_x      = EXT_W'(input_count_reg);
        is_drain = (s_data.func == gb3_pkg::FUNC_DRAIN);
        tail     = (c_x + w_x + EXT_W'(1)) >= size_x;
        push     = tail ? is_drain : !is_drain;
        in_wrap  = (p_x + EXT_W'(1)) >= size_x;

        if ((EXT_W'(in_col_reg) + EXT_W'(1)) >= w_x) begin
            in_col_inc = '0;
        end else begin
            in_col_inc = in_col_reg + ADDR_W'(1);
        end
        if ((EXT_W'(oc_col_reg) + EXT_W'(1)) >= w_x) begin
            oc_col_inc = '0;
        end else begin
            oc_col_inc = oc_col_reg + ADDR_W'(1);
        end

        s1_next.emit     = tail || (p_x >= (w_x + EXT_W'(1)));
        s1_next.blur_sel = (c_x >= (w_x + EXT_W'(1)))
                        && ((c_x + w_x + EXT_W'(2)) <= size_x);
        s1_next.last     = (c_x + EXT_W'(1)) >= size_x;
        s1_next.pix      = tail ? '0 : s_data.pixel_in;
        s1_next.addr     = tail ? oc_col_reg : in_col_reg;
    end

    // remainder steps
    assign rem_in_next = rem_step(rem_in_reg, div_in_reg[DIV_W-1], w_eff_reg);
    assign rem_oc_next = rem_step(rem_oc_reg, div_oc_reg[DIV_W-1], w_eff_reg);

    // config, counters, clearing pass and remainder unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= gb3_pkg::FW_W'(gb3_pkg::DEF_FRAME_WIDTH);
            frame_height_reg <= FH_W'(gb3_pkg::DEF_FRAME_HEIGHT);
            input_count_reg  <= '0;
            output_count_reg <= '0;
            in_col_reg       <= '0;
            oc_col_reg       <= ADDR_W'(1);
            clr_busy_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            div_cnt_reg      <= '0;
            div_in_reg       <= '0;
            div_oc_reg       <= '0;
            rem_in_reg       <= '0;
            rem_oc_reg       <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MAX_WIDTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (in_acc && push) begin
                if (!tail) begin
                    input_count_reg <= in_wrap ? '0 : input_count_reg + CNT_W'(1);
                    in_col_reg      <= in_wrap ? '0 : in_col_inc;
                end else begin
                    input_count_reg <= '0;
                    in_col_reg      <= '0;
                end
                if (s1_next.emit) begin
                    output_count_reg <= s1_next.last ? '0
                                                     : output_count_reg + CNT_W'(1);
                    oc_col_reg       <= s1_next.last ? ADDR_W'(1) : oc_col_inc;
                end
            end

            if (cfg_acc) begin
                case (cfg_index)
                    gb3_pkg::REG_FRAME_WIDTH: begin
                        frame_width_reg <= cfg_data[gb3_pkg::FW_W-1:0];
                    end
                    gb3_pkg::REG_FRAME_HEIGHT: begin
                        frame_height_reg <= cfg_data[FH_W-1:0];
                    end
                    default: begin
                    end
                endcase
                div_cnt_reg <= DCNT_W'(DIV_W + 1);
                div_in_reg  <= DIV_W'(input_count_reg);
                div_oc_reg  <= DIV_W'(output_count_reg) + DIV_W'(1);
                rem_in_reg  <= '0;
                rem_oc_reg  <= '0;
            end else if (div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                // first count waits for the clamped width to settle
                if (div_cnt_reg <= DCNT_W'(DIV_W)) begin
                    rem_in_reg <= rem_in_next;
                    rem_oc_reg <= rem_oc_next;
                    div_in_reg <= div_in_reg << 1;
                    div_oc_reg <= div_oc_reg << 1;
                    if (div_cnt_reg == DCNT_W'(1)) begin
                        in_col_reg <= rem_in_next[ADDR_W-1:0];
                        oc_col_reg <= rem_oc_next[ADDR_W-1:0];
                    end
                end
            end
        end
    end

    // forwarding around the read-before-write line buffer
    assign eff_pair        = fwd_valid_reg ? fwd_reg : rd_data;
    assign upd_pair.upper  = eff_pair.middle;
    assign upd_pair.middle = s1_reg.pix;

    assign wr_en   = clr_busy_reg || s1_adv;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : s1_reg.addr;
    assign wr_data = clr_busy_reg ? '0 : upd_pair;

    gb3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (in_acc && push),
        .rd_addr (s1_next.addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign win_col.top = eff_pair.upper;
    assign win_col.mid = eff_pair.middle;
    assign win_col.bot = s1_reg.pix;

    gb3_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (s1_adv),
        .col        (win_col),
        .blur_pix   (blur_pix),
        .center_pix (center_pix)
    );

    // stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_acc && push) begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= s1_valid_reg && (s1_reg.addr == s1_next.addr);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv && s1_reg.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && push) begin
            s1_reg  <= s1_next;
            fwd_reg <= upd_pair;
        end
        if (s1_adv && s1_reg.emit) begin
            out_data_reg.pixel_out  <= s1_reg.blur_sel ? blur_pix : center_pix;
            out_data_reg.frame_last <= s1_reg.last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
